// ----- sv/tlik_pkg.sv -----
// shared constants, types and helpers for the two-link arm inverse kinematics block
package tlik_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam int LEN_W    = 14;
    localparam int CRD_W    = 15;
    localparam int PAN_W    = 16;
    localparam int SH_W     = 17;
    localparam int EL_W     = 15;
    localparam int SQ_W     = 62;
    localparam int SQ_STEPS = 31;
    localparam int ROOT_W   = 31;
    localparam int CIN_W    = 32;
    localparam int CW       = 36;
    localparam int AW       = 34;
    localparam int TAB_N    = 32;

    localparam logic [LEN_W-1:0] UPPER_RST = 14'd4890;
    localparam logic [LEN_W-1:0] FORE_RST  = 14'd8020;

    localparam logic [0:0] REG_UPPER_ARM = 1'b0;
    localparam logic [0:0] REG_FOREARM   = 1'b1;

    localparam logic signed [CRD_W-1:0] SUB_X = 15'sd5120;
    localparam logic signed [CRD_W-1:0] SUB_Y = 15'sd7680;
    localparam logic [29:0] SUB_H2 = 30'd85196800;

    localparam logic signed [AW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [AW-1:0] Q30_HALF_PI = 34'sd1686629713;

    localparam logic signed [17:0] OUT_PI = 18'sd25736;
    localparam logic signed [17:0] SH_MIN = -18'sd12868;
    localparam logic signed [17:0] SH_MAX = 18'sd38604;

    localparam logic [29:0] ATAN_TAB [TAB_N] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    // round q30 radians to 1/8192 rad
    function automatic logic signed [17:0] to_out(input logic signed [34:0] q);
        logic signed [34:0] t;
        t = q + 35'sd65536;
        return t[34:17];
    endfunction

    typedef struct packed {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic signed [14:0] z;
        logic signed [15:0] pan;
        logic [28:0]        xx;
        logic [28:0]        yy;
        logic [28:0]        zz;
        logic               flag;
        logic               pannz;
        logic [29:0]        h2;
        logic [29:0]        r2;
        logic signed [31:0] num3;
        logic signed [31:0] num2;
        logic               sz;
        logic               neg3;
        logic               neg2;
        logic [30:0]        mag3;
        logic [30:0]        mag2;
        logic [43:0]        plo;
        logic [41:0]        phi;
        logic [61:0]        den2;
        logic [29:0]        hh3;
        logic [30:0]        hl3;
        logic [31:0]        ll3;
        logic [29:0]        hh2;
        logic [30:0]        hl2;
        logic [31:0]        ll2;
        logic [61:0]        nsq3;
        logic [61:0]        nsq2;
        logic               sat3;
        logic               sat2;
        logic [61:0]        diff3;
        logic [61:0]        diff2;
    } front_t;

    typedef struct packed {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic signed [14:0] z;
        logic signed [15:0] pan;
        logic               flag;
        logic               pannz;
        logic signed [31:0] num3;
        logic signed [31:0] num2;
        logic               sz;
        logic               sat3;
        logic               sat2;
        logic               neg3;
        logic               neg2;
    } side_a_t;

    typedef struct packed {
        logic signed [15:0] pan;
        logic               flag;
        logic               pannz;
        logic               sz;
        logic               sat3;
        logic               sat2;
        logic               neg3;
        logic               neg2;
    } side_b_t;

endpackage

// ----- sv/tlik_sqrt_cell.sv -----
// one digit step of the integer square root chain
module tlik_sqrt_cell #(
    parameter int BITEXP = 0
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [tlik_pkg::SQ_W-1:0] v_in,
    input  logic [tlik_pkg::SQ_W-1:0] res_in,
    output logic [tlik_pkg::SQ_W-1:0] v_out,
    output logic [tlik_pkg::SQ_W-1:0] res_out
);
    import tlik_pkg::*;

    localparam logic [SQ_W-1:0] BIT_VAL = {{(SQ_W-1){1'b0}}, 1'b1} << BITEXP;

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] v_next;
    logic [SQ_W-1:0] res_next;
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] res_reg;

    always_comb
    begin
        trial = res_in + BIT_VAL;
        if (v_in >= trial)
        begin
            v_next   = v_in - trial;
            res_next = (res_in >> 1) + BIT_VAL;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign v_out   = v_reg;
    assign res_out = res_reg;

endmodule

// ----- sv/tlik_sqrt.sv -----
// chain of square root cells, one result bit per cell
module tlik_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tlik_pkg::SQ_W-1:0]   value,
    output logic [tlik_pkg::ROOT_W-1:0] root
);
    import tlik_pkg::*;

    logic [SQ_W-1:0] sv [0:SQ_STEPS];
    logic [SQ_W-1:0] sr [0:SQ_STEPS];

    assign sv[0] = value;
    assign sr[0] = '0;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_cell
        tlik_sqrt_cell #(
            .BITEXP(2 * (SQ_STEPS - 1 - g))
        ) u_cell (
            .clk    (clk),
            .en     (en),
            .v_in   (sv[g]),
            .res_in (sr[g]),
            .v_out  (sv[g+1]),
            .res_out(sr[g+1])
        );
    end

    assign root = sr[SQ_STEPS][ROOT_W-1:0];

endmodule

// ----- sv/tlik_cordic_cell.sv -----
// one vectoring rotation of the cordic chain
module tlik_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [tlik_pkg::CW-1:0]  x_in,
    input  logic signed [tlik_pkg::CW-1:0]  y_in,
    input  logic signed [tlik_pkg::AW-1:0]  acc_in,
    input  logic                            zero_in,
    output logic signed [tlik_pkg::CW-1:0]  x_out,
    output logic signed [tlik_pkg::CW-1:0]  y_out,
    output logic signed [tlik_pkg::AW-1:0]  acc_out,
    output logic                            zero_out
);
    import tlik_pkg::*;

    localparam logic signed [AW-1:0] ANG = signed'(AW'(ATAN_TAB[STAGE]));

    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [AW-1:0] acc_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 zero_reg;

    always_comb
    begin
        if (y_in > 0)
        begin
            x_next   = x_in + (y_in >>> STAGE);
            y_next   = y_in - (x_in >>> STAGE);
            acc_next = acc_in + ANG;
        end
        else
        begin
            x_next   = x_in - (y_in >>> STAGE);
            y_next   = y_in + (x_in >>> STAGE);
            acc_next = acc_in - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            zero_reg <= zero_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign acc_out  = acc_reg;
    assign zero_out = zero_reg;

endmodule

// ----- sv/tlik_cordic.sv -----
// atan2 as a chain of cordic cells with quadrant fold and final clamp
module tlik_cordic #(
    parameter int STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [tlik_pkg::CIN_W-1:0] y_in,
    input  logic signed [tlik_pkg::CIN_W-1:0] x_in,
    output logic signed [tlik_pkg::AW-1:0]    angle
);
    import tlik_pkg::*;

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    logic signed [CW-1:0] px_next;
    logic signed [CW-1:0] py_next;
    logic signed [AW-1:0] pacc_next;
    logic                 pzero_next;

    logic signed [CW-1:0] cx   [0:STAGES];
    logic signed [CW-1:0] cy   [0:STAGES];
    logic signed [AW-1:0] cacc [0:STAGES];
    logic                 cz   [0:STAGES];

    logic signed [CW-1:0] px_reg;
    logic signed [CW-1:0] py_reg;
    logic signed [AW-1:0] pacc_reg;
    logic                 pzero_reg;
    logic signed [AW-1:0] angle_next;
    logic signed [AW-1:0] angle_reg;

    // fold the left half plane onto the right
    always_comb
    begin
        xe         = CW'(x_in);
        ye         = CW'(y_in);
        pzero_next = (x_in == '0) && (y_in == '0);
        px_next    = xe;
        py_next    = ye;
        pacc_next  = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                px_next   = ye;
                py_next   = -xe;
                pacc_next = Q30_HALF_PI;
            end
            else
            begin
                px_next   = -ye;
                py_next   = xe;
                pacc_next = -Q30_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            pacc_reg  <= pacc_next;
            pzero_reg <= pzero_next;
        end
    end

    assign cx[0]   = px_reg;
    assign cy[0]   = py_reg;
    assign cacc[0] = pacc_reg;
    assign cz[0]   = pzero_reg;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cell
        tlik_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .x_in    (cx[g]),
            .y_in    (cy[g]),
            .acc_in  (cacc[g]),
            .zero_in (cz[g]),
            .x_out   (cx[g+1]),
            .y_out   (cy[g+1]),
            .acc_out (cacc[g+1]),
            .zero_out(cz[g+1])
        );
    end

    always_comb
    begin
        if (cz[STAGES])
            angle_next = '0;
        else if (cacc[STAGES] > Q30_PI)
            angle_next = Q30_PI;
        else if (cacc[STAGES] < -Q30_PI)
            angle_next = -Q30_PI;
        else
            angle_next = cacc[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// ----- sv/two_link_arm_inverse_kinematics_top.sv -----
// top level of the two-link arm inverse kinematics pipeline
//
// input channel: in_valid/in_ready carries one target word (target_x, target_y,
// target_z, current_pan). output channel: out_valid/out_ready carries one joint
// command word (pan_angle, shoulder_angle, elbow_angle, out_of_reach) per input.
// link lengths are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, the block does not enforce it; the derived squares are registered.
// the pipeline is 8 front stages, 31 square root cells, CORDIC_STAGES + 2 cordic
// stages and the output register.
// throughput: one word per cycle while the output is not stalled; every stage is a register, the widest step
// is a 62-bit add and compare in a root cell or a 28 by 16 multiply.
// when out_ready is low and a word waits in the output register the pipeline
// keeps taking words until a finished word reaches its last stage, then the
// whole pipeline holds and in_ready drops.
// reset clears the valid chain and out_valid and loads the link
// lengths with their default values.
module two_link_arm_inverse_kinematics_top #(
    parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_index,
    input  logic [tlik_pkg::LEN_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [tlik_pkg::CRD_W-1:0] target_x,
    input  logic signed [tlik_pkg::CRD_W-1:0] target_y,
    input  logic signed [tlik_pkg::CRD_W-1:0] target_z,
    input  logic signed [tlik_pkg::PAN_W-1:0] current_pan,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [tlik_pkg::PAN_W-1:0] pan_angle,
    output logic signed [tlik_pkg::SH_W-1:0]  shoulder_angle,
    output logic [tlik_pkg::EL_W-1:0]         elbow_angle,
    output logic                              out_of_reach
);
    import tlik_pkg::*;

    localparam int CL  = CORDIC_STAGES + 2;
    localparam int LAT = 8 + SQ_STEPS + CL;

    logic [LEN_W-1:0] upper_reg;
    logic [LEN_W-1:0] fore_reg;

    logic [27:0] a2sq_reg;
    logic [27:0] a3sq_reg;
    logic [29:0] reachsq_reg;
    logic [28:0] den_reg;
    logic        a2z_reg;
    logic [27:0] dhh_reg;
    logic [28:0] dhl_reg;
    logic [29:0] dll_reg;
    logic [61:0] densq_reg;
    logic [14:0] reach;

    logic         en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    front_t st0_next, st1_next, st2_next, st3_next, st4_next, st5_next, st6_next, st7_next;
    front_t st0_reg, st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg, st7_reg;

    logic signed [29:0] sqx, sqy, sqz;
    logic [29:0]        h2c;
    logic [30:0]        r2c;

    side_a_t sa_reg [0:SQ_STEPS-1];
    side_a_t sa_last;
    side_b_t sb_reg [0:CL-1];
    side_b_t sb_last;

    logic [ROOT_W-1:0] root3, root2, rooth;
    logic signed [AW-1:0] ang_pan, ang_elev, ang_th2, ang_th3;

    logic signed [AW-1:0] th2q, th3q;
    logic signed [17:0]   pan18, sh18, el18;
    logic signed [PAN_W-1:0] pan_next;
    logic signed [SH_W-1:0]  sh_next;
    logic [EL_W-1:0]         el_next;
    logic signed [PAN_W-1:0] pan_reg;
    logic signed [SH_W-1:0]  sh_reg;
    logic [EL_W-1:0]         el_reg;
    logic                    oor_reg;

    // link length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RST;
            fore_reg  <= FORE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_UPPER_ARM)
                upper_reg <= cfg_data;
            if (cfg_index == REG_FOREARM)
                fore_reg <= cfg_data;
        end
    end

    // derived link terms
    assign reach = 15'(upper_reg) + 15'(fore_reg);

    always_ff @(posedge clk)
    begin
        a2sq_reg    <= 28'(upper_reg) * 28'(upper_reg);
        a3sq_reg    <= 28'(fore_reg) * 28'(fore_reg);
        reachsq_reg <= 30'(reach) * 30'(reach);
        den_reg     <= {28'(upper_reg) * 28'(fore_reg), 1'b0};
        a2z_reg     <= (upper_reg == '0);
        dhh_reg     <= 28'(den_reg[28:15]) * 28'(den_reg[28:15]);
        dhl_reg     <= 29'(den_reg[28:15]) * 29'(den_reg[14:0]);
        dll_reg     <= 30'(den_reg[14:0]) * 30'(den_reg[14:0]);
        densq_reg   <= (62'(dhh_reg) << 30) + (62'(dhl_reg) << 16) + 62'(dll_reg);
    end

    // flow control
    assign en       = !(vld_reg[LAT-1] && out_valid_reg && !out_ready);
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_comb
    begin
        if (en && vld_reg[LAT-1])
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // front stages
    always_comb
    begin
        st0_next     = '0;
        st0_next.x   = target_x;
        st0_next.y   = target_y;
        st0_next.z   = target_z;
        st0_next.pan = current_pan;
    end

    assign sqx = st0_reg.x * st0_reg.x;
    assign sqy = st0_reg.y * st0_reg.y;
    assign sqz = st0_reg.z * st0_reg.z;

    always_comb
    begin
        st1_next    = st0_reg;
        st1_next.xx = sqx[28:0];
        st1_next.yy = sqy[28:0];
        st1_next.zz = sqz[28:0];
    end

    // reach test and default target
    assign h2c = 30'(st1_reg.xx) + 30'(st1_reg.yy);
    assign r2c = 31'(h2c) + 31'(st1_reg.zz);

    always_comb
    begin
        st2_next      = st1_reg;
        st2_next.flag = (r2c > 31'(reachsq_reg));
        if (st2_next.flag)
        begin
            st2_next.x  = SUB_X;
            st2_next.y  = SUB_Y;
            st2_next.z  = '0;
            st2_next.h2 = SUB_H2;
            st2_next.r2 = SUB_H2;
        end
        else
        begin
            st2_next.h2 = h2c;
            st2_next.r2 = r2c[29:0];
        end
        st2_next.pannz = (st2_next.x != '0) || (st2_next.y != '0);
    end

    always_comb
    begin
        st3_next      = st2_reg;
        st3_next.num3 = signed'(32'(a2sq_reg) + 32'(a3sq_reg) - 32'(st2_reg.r2));
        st3_next.num2 = signed'(32'(a2sq_reg) - 32'(a3sq_reg) + 32'(st2_reg.r2));
        st3_next.sz   = a2z_reg || (st2_reg.r2 == '0);
        st3_next.plo  = 44'(a2sq_reg) * 44'(st2_reg.r2[15:0]);
        st3_next.phi  = 42'(a2sq_reg) * 42'(st2_reg.r2[29:16]);
    end

    always_comb
    begin
        st4_next      = st3_reg;
        st4_next.neg3 = st3_reg.num3[31];
        st4_next.neg2 = st3_reg.num2[31];
        st4_next.mag3 = st3_reg.num3[31] ? 31'(-st3_reg.num3) : 31'(st3_reg.num3);
        st4_next.mag2 = st3_reg.num2[31] ? 31'(-st3_reg.num2) : 31'(st3_reg.num2);
        st4_next.den2 = (62'(st3_reg.phi) << 18) + (62'(st3_reg.plo) << 2);
    end

    always_comb
    begin
        st5_next     = st4_reg;
        st5_next.hh3 = 30'(st4_reg.mag3[30:16]) * 30'(st4_reg.mag3[30:16]);
        st5_next.hl3 = 31'(st4_reg.mag3[30:16]) * 31'(st4_reg.mag3[15:0]);
        st5_next.ll3 = 32'(st4_reg.mag3[15:0]) * 32'(st4_reg.mag3[15:0]);
        st5_next.hh2 = 30'(st4_reg.mag2[30:16]) * 30'(st4_reg.mag2[30:16]);
        st5_next.hl2 = 31'(st4_reg.mag2[30:16]) * 31'(st4_reg.mag2[15:0]);
        st5_next.ll2 = 32'(st4_reg.mag2[15:0]) * 32'(st4_reg.mag2[15:0]);
    end

    always_comb
    begin
        st6_next      = st5_reg;
        st6_next.nsq3 = (62'(st5_reg.hh3) << 32) + (62'(st5_reg.hl3) << 17)
                      + 62'(st5_reg.ll3);
        st6_next.nsq2 = (62'(st5_reg.hh2) << 32) + (62'(st5_reg.hl2) << 17)
                      + 62'(st5_reg.ll2);
    end

    // cosine saturation and root operand
    always_comb
    begin
        st7_next       = st6_reg;
        st7_next.sat3  = (st6_reg.nsq3 >= densq_reg);
        st7_next.diff3 = densq_reg - st6_reg.nsq3;
        st7_next.sat2  = (st6_reg.nsq2 >= st6_reg.den2);
        st7_next.diff2 = st6_reg.den2 - st6_reg.nsq2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st0_reg <= st0_next;
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
            st6_reg <= st6_next;
            st7_reg <= st7_next;
        end
    end

    // square roots
    tlik_sqrt u_sqrt3 (
        .clk  (clk),
        .en   (en),
        .value(st7_reg.diff3),
        .root (root3)
    );

    tlik_sqrt u_sqrt2 (
        .clk  (clk),
        .en   (en),
        .value(st7_reg.diff2),
        .root (root2)
    );

    tlik_sqrt u_sqrth (
        .clk  (clk),
        .en   (en),
        .value(62'(st7_reg.h2)),
        .root (rooth)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg[0].x     <= st7_reg.x;
            sa_reg[0].y     <= st7_reg.y;
            sa_reg[0].z     <= st7_reg.z;
            sa_reg[0].pan   <= st7_reg.pan;
            sa_reg[0].flag  <= st7_reg.flag;
            sa_reg[0].pannz <= st7_reg.pannz;
            sa_reg[0].num3  <= st7_reg.num3;
            sa_reg[0].num2  <= st7_reg.num2;
            sa_reg[0].sz    <= st7_reg.sz;
            sa_reg[0].sat3  <= st7_reg.sat3;
            sa_reg[0].sat2  <= st7_reg.sat2;
            sa_reg[0].neg3  <= st7_reg.neg3;
            sa_reg[0].neg2  <= st7_reg.neg2;
            for (int k = 1; k < SQ_STEPS; k++)
                sa_reg[k] <= sa_reg[k-1];
        end
    end

    assign sa_last = sa_reg[SQ_STEPS-1];

    // angles
    tlik_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic_pan (
        .clk  (clk),
        .en   (en),
        .y_in (CIN_W'(sa_last.y)),
        .x_in (CIN_W'(sa_last.x)),
        .angle(ang_pan)
    );

    tlik_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic_elev (
        .clk  (clk),
        .en   (en),
        .y_in (CIN_W'(sa_last.z)),
        .x_in (signed'(CIN_W'(rooth))),
        .angle(ang_elev)
    );

    tlik_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic_th2 (
        .clk  (clk),
        .en   (en),
        .y_in (signed'(CIN_W'(root2))),
        .x_in (sa_last.num2),
        .angle(ang_th2)
    );

    tlik_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic_th3 (
        .clk  (clk),
        .en   (en),
        .y_in (signed'(CIN_W'(root3))),
        .x_in (sa_last.num3),
        .angle(ang_th3)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0].pan   <= sa_last.pan;
            sb_reg[0].flag  <= sa_last.flag;
            sb_reg[0].pannz <= sa_last.pannz;
            sb_reg[0].sz    <= sa_last.sz;
            sb_reg[0].sat3  <= sa_last.sat3;
            sb_reg[0].sat2  <= sa_last.sat2;
            sb_reg[0].neg3  <= sa_last.neg3;
            sb_reg[0].neg2  <= sa_last.neg2;
            for (int k = 1; k < CL; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    assign sb_last = sb_reg[CL-1];

    // joint commands
    always_comb
    begin
        if (sb_last.sz)
            th2q = '0;
        else if (sb_last.sat2)
            th2q = sb_last.neg2 ? Q30_PI : '0;
        else
            th2q = ang_th2;

        if (sb_last.sat3)
            th3q = sb_last.neg3 ? Q30_PI : '0;
        else
            th3q = ang_th3;

        pan18 = to_out(35'(ang_pan));
        sh18  = to_out(35'(ang_elev) + 35'(th2q));
        el18  = OUT_PI - to_out(35'(th3q));

        pan_next = sb_last.pannz ? pan18[PAN_W-1:0] : sb_last.pan;

        if (sh18 < SH_MIN)
            sh_next = SH_MIN[SH_W-1:0];
        else if (sh18 > SH_MAX)
            sh_next = SH_MAX[SH_W-1:0];
        else
            sh_next = sh18[SH_W-1:0];

        if (el18 < 0)
            el_next = '0;
        else if (el18 > OUT_PI)
            el_next = OUT_PI[EL_W-1:0];
        else
            el_next = el18[EL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[LAT-1])
        begin
            pan_reg <= pan_next;
            sh_reg  <= sh_next;
            el_reg  <= el_next;
            oor_reg <= sb_last.flag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pan_angle      = pan_reg;
    assign shoulder_angle = sh_reg;
    assign elbow_angle    = el_reg;
    assign out_of_reach   = oor_reg;

endmodule
